// ===== design/sha256_pkg.sv =====
// shared types, constants and round functions of the sha-256 stream hasher
`default_nettype none

package sha256_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned LEN_W       = 64;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word INITIAL_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== design/sha256_stream_hasher.sv =====
// top level of the sha-256 stream hasher: byte loader, padder, round unit and digest output
`default_nettype none

// SHA-256 over a byte stream. Each request on the slave side carries one
// message byte in s_axis_tdata, a byte-present flag in s_axis_tuser and an
// end-of-message mark in s_axis_tlast; a request with the flag low and the mark
// high finishes the message without adding a byte (an empty message gives the
// hash of the empty string). Bytes are shifted into a 512-bit block register at
// one per cycle while s_axis_tready is high. When 64 bytes are in, a single
// shared round unit runs the 64 compression rounds, one per cycle, with the
// message schedule computed in place in a sixteen-word window, followed by an
// add step that adds the working variables into the hash; s_axis_tready is
// low during the rounds and the add step. On the end mark the padder shifts in
// 0x80, zero fill and the 64-bit bit length one byte per cycle (over two
// blocks, and so two compressions, when 56 or more bytes were pending), then
// the eight digest words are offered on the master side, index 0 (most
// significant) first, tlast on index 7. After the last word is taken the hash
// returns to its initial value and the block accepts the next message. The
// bit length wraps modulo 2^64.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: message bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // master side: digest words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    t_state            r_state, n_state;
    t_word             r_hash [HASH_WORDS];
    t_word             n_hash [HASH_WORDS];
    t_word             r_v    [HASH_WORDS];    // working variables a..h
    t_word             n_v    [HASH_WORDS];
    t_word             r_w    [BLOCK_WORDS];   // block bytes, then schedule window
    t_word             n_w    [BLOCK_WORDS];
    logic [LEN_W-1:0]  r_len, n_len;
    logic [5:0]        r_pos, n_pos;           // byte position in the block
    logic [5:0]        r_rnd, n_rnd;           // round counter
    logic [2:0]        r_idx, n_idx;           // digest word on offer
    logic              r_fin, n_fin;           // message end seen
    logic              r_put80, n_put80;       // pad byte already placed
    logic              r_long, n_long;         // pad byte landed in the length field
    logic              r_lenblk, n_lenblk;     // block under compression holds the length

    // combinational helpers
    logic              in_req;
    logic              out_req;
    logic              shift_en;
    logic [7:0]        shift_byte;
    logic              is_len;
    logic [LEN_W-1:0]  len_shifted;
    t_word             t1, t2, w_new;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_hash[r_idx];
    assign m_axis_tuser  = r_idx;
    assign m_axis_tlast  = (r_idx == WORD_LAST);

    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;

    // length bytes go out most significant first at positions 56..63
    assign is_len      = r_put80 && !r_long && (r_pos >= LEN_START);
    assign len_shifted = r_len << {r_pos[2:0], 3'b000};

    // one round of compression and one step of the schedule
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[r_rnd] + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    always_comb begin
        n_state  = r_state;
        n_hash   = r_hash;
        n_v      = r_v;
        n_w      = r_w;
        n_len    = r_len;
        n_pos    = r_pos;
        n_rnd    = r_rnd;
        n_idx    = r_idx;
        n_fin    = r_fin;
        n_put80  = r_put80;
        n_long   = r_long;
        n_lenblk = r_lenblk;
        shift_en   = 1'b0;
        shift_byte = s_axis_tdata;

        case (r_state)
            ST_IDLE: begin
                if (in_req) begin
                    n_fin = s_axis_tlast;
                    if (s_axis_tuser) begin
                        shift_en = 1'b1;
                        n_len    = r_len + LEN_W'(8);
                        n_pos    = r_pos + 6'd1;
                    end
                    if (s_axis_tuser && (r_pos == BLOCK_LAST)) begin
                        // block full: compress now, pad afterwards if the end came too
                        n_state  = ST_ROUND;
                        n_rnd    = '0;
                        n_v      = r_hash;
                        n_lenblk = 1'b0;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                shift_en = 1'b1;
                if (!r_put80) begin
                    shift_byte = PAD_BYTE;
                end else if (is_len) begin
                    shift_byte = len_shifted[LEN_W-1 -: 8];
                end else begin
                    shift_byte = 8'h00;
                end
                n_put80 = 1'b1;
                if (!r_put80 && (r_pos >= LEN_START)) begin
                    n_long = 1'b1;
                end
                n_pos = r_pos + 6'd1;
                if (r_pos == BLOCK_LAST) begin
                    n_state  = ST_ROUND;
                    n_rnd    = '0;
                    n_v      = r_hash;
                    n_lenblk = is_len;
                    n_long   = 1'b0;
                end
            end
            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                    n_w[j] = r_w[j+1];
                end
                n_w[BLOCK_WORDS-1] = w_new;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'(ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    n_hash[i] = r_hash[i] + r_v[i];
                end
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_lenblk) begin
                    n_state = ST_OUT;
                    n_idx   = '0;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_req) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == WORD_LAST) begin
                        // digest delivered: back to the initial state
                        n_state  = ST_IDLE;
                        n_hash   = INITIAL_HASH;
                        n_len    = '0;
                        n_pos    = '0;
                        n_fin    = 1'b0;
                        n_put80  = 1'b0;
                        n_long   = 1'b0;
                        n_lenblk = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // byte shift: oldest byte ends up in the top of word 0
        if (shift_en) begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                n_w[j] = {r_w[j][23:0], r_w[j+1][31:24]};
            end
            n_w[BLOCK_WORDS-1] = {r_w[BLOCK_WORDS-1][23:0], shift_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hash   <= INITIAL_HASH;
            r_len    <= '0;
            r_pos    <= '0;
            r_rnd    <= '0;
            r_idx    <= '0;
            r_fin    <= 1'b0;
            r_put80  <= 1'b0;
            r_long   <= 1'b0;
            r_lenblk <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hash   <= n_hash;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_rnd    <= n_rnd;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
            r_put80  <= n_put80;
            r_long   <= n_long;
            r_lenblk <= n_lenblk;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

endmodule

`default_nettype wire

// ===== design/sha256_checker.sv =====
// port-level assertions of the sha-256 stream hasher and their bind
`default_nettype none

module sha256_checker
    import sha256_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // input is never taken while a digest is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest output valid");

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("digest word changed while stalled");

    // digest words follow one another in index order
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1)))
        else $error("digest word index out of order");

    // tlast marks exactly the final word
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == WORD_LAST)))
        else $error("tlast not on the final digest word");

    // after the final word the block is ready for a new message
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid && s_axis_tready))
        else $error("not back to idle after the digest");

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== sim/sha256_digest_checker.sv =====
// digest checker: models sha-256 over accepted byte requests and compares the digest words
`timescale 1ns / 100ps

module sha256_digest_checker
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // last_byte
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,   // [31:0] digest_word
    input  wire logic [2:0]  m_axis_tuser,   // [2:0] word_index
    input  wire logic        m_axis_tlast,   // last_word
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    t_word        chain_words [HASH_WORDS];
    t_word        msg_words [BLOCK_WORDS];
    logic [63:0]  bit_count;
    logic [5:0]   fill_pos;
    t_digest_beat digest_due [$];
    int           fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_word ror32(input t_word x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_block();
        for (int i = 0; i < BLOCK_WORDS; i++) msg_words[i] = '0;
        fill_pos = '0;
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < HASH_WORDS; i++) chain_words[i] = INITIAL_HASH[i];
        clear_block();
        bit_count = '0;
    endfunction

    // big-endian placement of one byte in the current block
    function automatic void place_byte(input logic [7:0] b);
        msg_words[fill_pos[5:2]] |= t_word'(b) << (24 - 8 * fill_pos[1:0]);
        fill_pos = fill_pos + 6'd1;
    endfunction

    function automatic void compress_block();
        t_word w [64];
        t_word v [8];
        t_word s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = msg_words[t];
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain_words[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
    endfunction

    // one byte request: absorb, and on the end mark pad and queue the digest
    function automatic void absorb_request(input logic [7:0] b, input logic has,
                                           input logic fin);
        logic [5:0]   pend;
        t_digest_beat beat;
        if (has) begin
            bit_count = bit_count + 64'd8;
            place_byte(b);
            if (fill_pos == 6'd0) begin
                compress_block();
                clear_block();
            end
        end
        if (fin) begin
            pend = fill_pos;
            place_byte(PAD_BYTE);
            // no room for the length: it goes into a zeroed extra block
            if (pend >= LEN_START) begin
                compress_block();
                clear_block();
            end
            msg_words[14] = bit_count[63:32];
            msg_words[15] = bit_count[31:0];
            compress_block();
            for (int i = 0; i < HASH_WORDS; i++) begin
                beat.word  = chain_words[i];
                beat.index = 3'(i);
                beat.last  = (i == HASH_WORDS - 1);
                digest_due.push_back(beat);
            end
            restart_hash();
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_digest_beat want;
        if (!i_rst_n) begin
            restart_hash();
            digest_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_due.size() == 0) begin
                    $error("digest_word: expected none, actual %h", m_axis_tdata);
                    fails++;
                end else begin
                    want = digest_due.pop_front();
                    if (m_axis_tdata !== want.word) begin
                        $error("digest_word: expected %h, actual %h", want.word, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tuser !== want.index) begin
                        $error("word_index: expected %0d, actual %0d", want.index, m_axis_tuser);
                        fails++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_word: expected %b, actual %b", want.last, m_axis_tlast);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        end
        o_fail_count <= fails;
        o_pending    <= digest_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: byte stimulus, digest-side back-pressure, watchdog and verdict
`timescale 1ns / 100ps

module tb_top;

    localparam int ITEM_TARGET = 480;
    localparam int QUIET_LIMIT = 4000;   // cycles without any request moving
    localparam int TAIL_CYCLES = 300;    // covers a two-block pad and the digest

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] has_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_index
    logic        m_axis_tlast;           // last_word

    int       fail_count;
    int       pending;
    int       items_sent = 0;
    int       burst_left = 0;
    bit       idle_on = 1'b1;
    int       quiet_cycles = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_period = 2;
    int       rx_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sha256_stream_hasher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_digest_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // digest side back-pressure: a random mode held for a random stretch
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_left   = $urandom_range(20, 300);
            rx_period = $urandom_range(2, 9);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_count % rx_period == 0);
            default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // watchdog on cycles where neither side moves a request
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one byte request; the sender runs in bursts with random gaps between them while idling is on
    task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // a message of random bytes, ended on its last byte or by a bare finish
    task automatic send_message(input int len, input bit bare_finish, input bit noisy);
        for (int k = 0; k < len; k++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !bare_finish);
        end
        if (len == 0 || bare_finish)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // mostly short messages, with the pad and block boundaries hit often
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 8);
        if (r < 70)
            return $urandom_range(9, 54);
        if (r < 88) begin
            case ($urandom_range(0, 5))
                0:       return 55;
                1:       return 56;
                2:       return 57;
                3:       return 63;
                4:       return 64;
                default: return 65;
            endcase
        end
        case ($urandom_range(0, 4))
            0:       return 119;
            1:       return 120;
            2:       return 127;
            3:       return 128;
            default: return $urandom_range(66, 130);
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored step, empty message, byte extremes, bare finish, "abc"
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // random messages, idling switched per message
        while (items_sent < ITEM_TARGET) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_message(pick_length(), ($urandom_range(0, 3) == 0),
                         ($urandom_range(0, 2) == 0));
        end
        s_axis_tvalid <= 1'b0;

        // let the checker take in the final request before reading its queue depth
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sha256_stream_hasher.f =====
design/sha256_pkg.sv
design/sha256_stream_hasher.sv
design/sha256_checker.sv
sim/sha256_digest_checker.sv
sim/tb_top.sv
